/* src/sfbl_pkg.sv */
// Shared constants and types for the sorted free block list.
package sfbl_pkg;

  localparam int CAPACITY   = 64;
  localparam int BLOCK_BITS = 16;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);

  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_POP    = 1'b1;

  typedef logic [BLOCK_BITS-1:0] block_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef struct packed {
    logic ins;
    logic pop;
  } cell_cmd_t;

endpackage

/* src/sfbl_cell.sv */
// One storage cell of the sorted list: compare, shift in, shift out.
module sfbl_cell
  import sfbl_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  block_t    num,
  input  logic      occupied,
  input  logic      tail,
  input  logic      prev_place,
  input  block_t    prev_val,
  input  block_t    next_val,
  output block_t    val,
  output logic      place
);

  assign place = occupied && (num < val);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (prev_place) begin
        val <= prev_val;
      end else if (place || tail) begin
        val <= num;
      end
    end else if (cmd.pop) begin
      val <= next_val;
    end
  end

endmodule

/* src/sorted_free_block_list_top.sv */
// Top level of the sorted free block list: cell chain, count and result register.
//
// Keeps up to CAPACITY block numbers in ascending order in a row of cells.
// An insert (func 0) goes in after every stored number that is less than or
// equal to it; a pop (func 1) returns the lowest number. Each transfer in
// yields one result transfer out. Every cell compares the new number with
// its own in parallel and the cells shift together, so the block takes one
// item per cycle while the result register drains; a new item waits only
// while a result is held by a stalled consumer. Inserts into a full list
// are dropped and flagged; pops from an empty list return zero.
module sorted_free_block_list_top
  import sfbl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // func[0], block_number[16:1], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // block_out[15:0], got_block[16],
                                     // rejected_full[17], has_free[18],
                                     // entry_count[25:19], zero pad
);

  logic       in_fire;
  logic       func;
  block_t     num;
  count_t     count;
  count_t     count_next;
  cell_cmd_t  cmd;
  block_t     cell_val   [CAPACITY];
  logic       cell_place [CAPACITY];

  logic [15:0] block_out;
  logic        got_block;
  logic        rejected_full;
  logic        has_free;
  logic [6:0]  entry_count;

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign func     = s_tdata[0];
  assign num      = s_tdata[BLOCK_BITS:1];

  assign cmd.ins = in_fire && (func == FUNC_INSERT) && (count < count_t'(CAPACITY));
  assign cmd.pop = in_fire && (func == FUNC_POP) && (count != '0);

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + count_t'(1);
    end else if (cmd.pop) begin
      count_next = count - count_t'(1);
    end
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic   prev_place;
    block_t prev_val;
    block_t next_val;

    if (gi == 0) begin : g_head
      assign prev_place = 1'b0;
      assign prev_val   = '0;
    end else begin : g_body
      assign prev_place = cell_place[gi-1];
      assign prev_val   = cell_val[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = cell_val[gi+1];
    end

    sfbl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .num        (num),
      .occupied   (count_t'(gi) < count),
      .tail       (count_t'(gi) == count),
      .prev_place (prev_place),
      .prev_val   (prev_val),
      .next_val   (next_val),
      .val        (cell_val[gi]),
      .place      (cell_place[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      block_out     <= cmd.pop ? 16'(cell_val[0]) : 16'd0;
      got_block     <= cmd.pop;
      rejected_full <= (func == FUNC_INSERT) && !cmd.ins;
      has_free      <= (count_next != '0);
      entry_count   <= 7'(count_next);
    end
  end

  assign m_tdata = {6'd0, entry_count, has_free, rejected_full, got_block, block_out};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(CAPACITY))
    else $error("stored count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (in_fire && func == FUNC_INSERT && count < count_t'(CAPACITY))
      |=> count == $past(count) + count_t'(1))
    else $error("accepted insert did not grow the list");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= count_t'(2)) |-> (cell_val[0] <= cell_val[1]))
    else $error("head cells out of order");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (m_tvalid && got_block && block_out == 16'($past(cell_val[0]))))
    else $error("pop result does not match head cell");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for the sorted free block list: stream driver, result monitor and list predictor.
module tb_top
  import sfbl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic   func;
    block_t num;
  } op_item_t;

  typedef struct packed {
    block_t block_out;
    logic   got_block;
    logic   rejected_full;
    logic   has_free;
    count_t entry_count;
  } op_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  op_item_t   pending_ops[$];
  op_result_t expected_results[$];
  block_t     free_blocks[$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_req = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  mismatch_count = 0;
  int  quiet_cycles = 0;
  logic in_fired = 1'b0;

  sorted_free_block_list_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // Apply one operation to the sorted list and return the result it produces.
  function automatic op_result_t apply_op(op_item_t op);
    op_result_t r;
    int pos;
    r = '0;
    if (op.func == FUNC_INSERT) begin
      if (free_blocks.size() >= CAPACITY) begin
        r.rejected_full = 1'b1;
      end else begin
        pos = 0;
        while (pos < free_blocks.size() && free_blocks[pos] <= op.num) pos++;
        free_blocks.insert(pos, op.num);
      end
    end else begin
      if (free_blocks.size() > 0) begin
        r.block_out = free_blocks.pop_front();
        r.got_block = 1'b1;
      end
    end
    r.has_free    = (free_blocks.size() != 0);
    r.entry_count = count_t'(free_blocks.size());
    return r;
  endfunction

  function automatic block_t pick_block();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel < 2) return block_t'($urandom_range(0, 15));
    if (sel == 2) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    return block_t'($urandom);
  endfunction

  task automatic queue_op(logic func, block_t num);
    op_item_t op;
    op.func = func;
    op.num  = num;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Random traffic: bursts of inserts and pops, mixed runs and duplicate runs.
  task automatic queue_random(int n_items);
    int queued;
    int len;
    int kind;
    block_t dup_base;
    queued = 0;
    while (queued < n_items) begin
      kind = $urandom_range(0, 3);
      case (kind)
        0: begin
          len = $urandom_range(40, 72);
          repeat (len) queue_op(FUNC_INSERT, pick_block());
        end
        1: begin
          len = $urandom_range(20, 72);
          repeat (len) queue_op(FUNC_POP, block_t'($urandom));
        end
        2: begin
          len = $urandom_range(8, 24);
          repeat (len)
            queue_op($urandom_range(0, 1) ? FUNC_POP : FUNC_INSERT, pick_block());
        end
        default: begin
          len = $urandom_range(4, 16);
          dup_base = pick_block();
          repeat (len) queue_op(FUNC_INSERT, dup_base + block_t'($urandom_range(0, 2)));
        end
      endcase
      queued += len;
    end
  endtask

  always @(negedge clk) begin
    op_item_t next_op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fired) begin
      if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_op = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({next_op.num, next_op.func});
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    op_result_t want;
    op_result_t got;
    op_item_t   op;
    in_fired <= s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got.block_out     = m_tdata[15:0];
      got.got_block     = m_tdata[16];
      got.rejected_full = m_tdata[17];
      got.has_free      = m_tdata[18];
      got.entry_count   = m_tdata[25:19];
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.block_out != want.block_out) begin
          $error("block_out mismatch: expected %h, actual %h", want.block_out, got.block_out);
          mismatch_count++;
        end
        if (got.got_block != want.got_block) begin
          $error("got_block mismatch: expected %b, actual %b", want.got_block, got.got_block);
          mismatch_count++;
        end
        if (got.rejected_full != want.rejected_full) begin
          $error("rejected_full mismatch: expected %b, actual %b",
                 want.rejected_full, got.rejected_full);
          mismatch_count++;
        end
        if (got.has_free != want.has_free) begin
          $error("has_free mismatch: expected %b, actual %b", want.has_free, got.has_free);
          mismatch_count++;
        end
        if (got.entry_count != want.entry_count) begin
          $error("entry_count mismatch: expected %0d, actual %0d",
                 want.entry_count, got.entry_count);
          mismatch_count++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      op.func = s_tdata[0];
      op.num  = s_tdata[16:1];
      expected_results.insert(expected_results.size(), apply_op(op));
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    queue_op(FUNC_POP, '1);
    queue_op(FUNC_INSERT, '1);
    queue_op(FUNC_INSERT, '0);
    queue_op(FUNC_INSERT, 16'h8000);
    queue_op(FUNC_INSERT, 16'h7FFF);
    queue_op(FUNC_INSERT, 16'h0005);
    queue_op(FUNC_INSERT, 16'h0005);
    queue_op(FUNC_INSERT, 16'h0005);
    repeat (7) queue_op(FUNC_POP, 16'h5555);
    queue_op(FUNC_POP, 16'hAAAA);
    queue_op(FUNC_INSERT, 16'h0001);
    queue_op(FUNC_INSERT, 16'h0001);
    queue_op(FUNC_POP, '0);
    queue_op(FUNC_POP, '1);
    queue_op(FUNC_POP, '0);
    wait_drained();

    // no idling, with one long receiver hold-off at the start
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req++;
    queue_random(420);
    wait_drained();

    send_idle_pct  = 66;
    recv_stall_pct = 0;
    queue_random(420);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 66;
    queue_random(420);
    wait_drained();

    send_idle_pct  = 27;
    recv_stall_pct = 27;
    hold_req++;
    queue_random(420);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sorted_free_block_list_top.f */
src/sfbl_pkg.sv
src/sfbl_cell.sv
src/sorted_free_block_list_top.sv
tb/tb_top.sv
